[src/rhpp_pkg.sv]
// Package for the range hold push pulser: payload types, config indexes, widths.
package rhpp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned CntW     = 15;
  localparam int unsigned PushW    = 7;

  localparam logic [CfgIdxW-1:0] CFG_HORIZ_UPPER     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HORIZ_LOWER     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_VERT_UPPER      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_VERT_LOWER      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HORIZ_PUSH      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_HORIZ_PULSE_LEN = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_VERT_PUSH       = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_VERT_PULSE_LEN  = 3'd7;

  typedef struct packed {
    logic              range_fresh;
    logic signed [7:0] horiz_range;
    logic signed [7:0] vert_range;
  } in_beat_t;

  typedef struct packed {
    logic signed [7:0] forward_push;
    logic signed [7:0] upward_push;
  } out_beat_t;

  // pulse activity of one axis for the current tick
  typedef struct packed {
    logic hi_act;
    logic lo_act;
  } axis_act_t;

endpackage

[src/rhpp_axis.sv]
// One axis: two hysteresis latches and two pulse counters, updated once per tick.
module rhpp_axis (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          fresh,
  input  logic signed [7:0]             range_val,
  input  logic signed [7:0]             upper,
  input  logic signed [7:0]             lower,
  input  logic [rhpp_pkg::CntW-1:0]     seed,
  input  logic [rhpp_pkg::CntW-1:0]     pulse_len,
  output rhpp_pkg::axis_act_t           act
);

  logic                      hi_l_r, lo_l_r;
  logic [rhpp_pkg::CntW-1:0] hi_c_r, lo_c_r;
  logic                      hi_l_nxt, lo_l_nxt;
  logic [rhpp_pkg::CntW-1:0] hi_c_nxt, lo_c_nxt;
  logic                      hi_l_mid, lo_l_mid;
  logic [rhpp_pkg::CntW-1:0] hi_c_mid, lo_c_mid;

  always_comb begin
    hi_l_mid = hi_l_r;
    lo_l_mid = lo_l_r;
    hi_c_mid = hi_c_r;
    lo_c_mid = lo_c_r;
    if (fresh) begin
      // leaving the band
      if (range_val > upper && !hi_l_r) begin
        hi_c_mid = rhpp_pkg::CntW'(1);
        hi_l_mid = 1'b1;
      end else if (range_val < lower && !lo_l_r) begin
        lo_c_mid = rhpp_pkg::CntW'(1);
        lo_l_mid = 1'b1;
      end
      // back in the band: brake the other way
      if (hi_l_mid && range_val < upper) begin
        hi_l_mid = 1'b0;
        lo_c_mid = seed;
      end else if (lo_l_mid && range_val > lower) begin
        lo_l_mid = 1'b0;
        hi_c_mid = seed;
      end
    end
    act.hi_act = (hi_c_mid != '0) && (hi_c_mid < pulse_len);
    act.lo_act = (lo_c_mid != '0) && (lo_c_mid < pulse_len);
    hi_l_nxt   = hi_l_mid;
    lo_l_nxt   = lo_l_mid;
    hi_c_nxt   = act.hi_act ? hi_c_mid + rhpp_pkg::CntW'(1) : '0;
    lo_c_nxt   = act.lo_act ? lo_c_mid + rhpp_pkg::CntW'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_l_r <= 1'b0;
      lo_l_r <= 1'b0;
      hi_c_r <= '0;
      lo_c_r <= '0;
    end else if (step) begin
      hi_l_r <= hi_l_nxt;
      lo_l_r <= lo_l_nxt;
      hi_c_r <= hi_c_nxt;
      lo_c_r <= lo_c_nxt;
    end
  end

endmodule

[src/range_hold_push_pulser_top.sv]
// Top level of the range hold push pulser: config registers, input and result stages.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------------
//   in       | in_valid / in_ready      | in_data  (rhpp_pkg::in_beat_t)
//   out      | out_valid / out_ready    | out_data (rhpp_pkg::out_beat_t)
//   cfg      | cfg_wr_en                | cfg_index, cfg_data
//
// One beat per cycle while out_ready holds; the result register follows the input.
// A beat sits in the input register, the axis logic updates latches and counters and
// loads the result register in the same cycle. Synchronous active-low reset clears
// config to defaults and all latches and counters. A stalled result holds the input
// stage; in_ready drops at once if it is full, else after it takes one more beat.
module range_hold_push_pulser_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rhpp_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rhpp_pkg::out_beat_t               out_data,
  input  logic                              cfg_wr_en,
  input  logic [rhpp_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [rhpp_pkg::CfgDataW-1:0]     cfg_data
);

  logic signed [7:0]          horiz_upper_r, horiz_lower_r, vert_upper_r, vert_lower_r;
  logic [rhpp_pkg::PushW-1:0] horiz_push_r, vert_push_r;
  logic [rhpp_pkg::CntW-1:0]  horiz_len_r, vert_len_r;

  logic                       s1_valid_r;
  rhpp_pkg::in_beat_t         s1_data_r;
  logic                       out_valid_r;
  rhpp_pkg::out_beat_t        out_data_r;
  rhpp_pkg::out_beat_t        out_data_nxt;
  logic                       s1_go;
  rhpp_pkg::axis_act_t        h_act, v_act;
  logic [rhpp_pkg::CntW-1:0]  h_seed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horiz_upper_r <= 8'sd100;
      horiz_lower_r <= 8'sd50;
      vert_upper_r  <= 8'sd100;
      vert_lower_r  <= 8'sd50;
      horiz_push_r  <= 7'd20;
      horiz_len_r   <= 15'd50;
      vert_push_r   <= 7'd20;
      vert_len_r    <= 15'd50;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rhpp_pkg::CFG_HORIZ_UPPER:     horiz_upper_r <= cfg_data[7:0];
        rhpp_pkg::CFG_HORIZ_LOWER:     horiz_lower_r <= cfg_data[7:0];
        rhpp_pkg::CFG_VERT_UPPER:      vert_upper_r  <= cfg_data[7:0];
        rhpp_pkg::CFG_VERT_LOWER:      vert_lower_r  <= cfg_data[7:0];
        rhpp_pkg::CFG_HORIZ_PUSH:      horiz_push_r  <= cfg_data[rhpp_pkg::PushW-1:0];
        rhpp_pkg::CFG_HORIZ_PULSE_LEN: horiz_len_r   <= cfg_data[rhpp_pkg::CntW-1:0];
        rhpp_pkg::CFG_VERT_PUSH:       vert_push_r   <= cfg_data[rhpp_pkg::PushW-1:0];
        rhpp_pkg::CFG_VERT_PULSE_LEN:  vert_len_r    <= cfg_data[rhpp_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // horizontal brake seeded with half the push
  assign h_seed = rhpp_pkg::CntW'(horiz_push_r >> 1);

  rhpp_axis u_horiz (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .fresh     (s1_data_r.range_fresh),
    .range_val (s1_data_r.horiz_range),
    .upper     (horiz_upper_r),
    .lower     (horiz_lower_r),
    .seed      (h_seed),
    .pulse_len (horiz_len_r),
    .act       (h_act)
  );

  rhpp_axis u_vert (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .fresh     (s1_data_r.range_fresh),
    .range_val (s1_data_r.vert_range),
    .upper     (vert_upper_r),
    .lower     (vert_lower_r),
    .seed      (rhpp_pkg::CntW'(1)),
    .pulse_len (vert_len_r),
    .act       (v_act)
  );

  // hi side: back (negative) horizontally, up (positive) vertically; back and down win
  always_comb begin
    if (h_act.hi_act) begin
      out_data_nxt.forward_push = 8'sd0 - $signed({1'b0, horiz_push_r});
    end else if (h_act.lo_act) begin
      out_data_nxt.forward_push = $signed({1'b0, horiz_push_r});
    end else begin
      out_data_nxt.forward_push = 8'sd0;
    end
    if (v_act.lo_act) begin
      out_data_nxt.upward_push = 8'sd0 - $signed({1'b0, vert_push_r});
    end else if (v_act.hi_act) begin
      out_data_nxt.upward_push = $signed({1'b0, vert_push_r});
    end else begin
      out_data_nxt.upward_push = 8'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/rhpp_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the range hold push pulser: mirrors config, predicts each tick, checks results.
module rhpp_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  rhpp_pkg::in_beat_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  rhpp_pkg::out_beat_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [rhpp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rhpp_pkg::CfgDataW-1:0] cfg_data,
  output int                            fails,
  output int                            pending,
  output int                            checked
);

  logic signed [7:0]          h_upper, h_lower, v_upper, v_lower;
  logic [rhpp_pkg::PushW-1:0] h_push, v_push;
  logic [rhpp_pkg::CntW-1:0]  h_len, v_len;

  logic              go_back, go_fwd, go_up, go_down;
  logic [15:0]       fwd_cnt, back_cnt, up_cnt, down_cnt;
  logic [7:0]        fwd_hold, up_hold;

  rhpp_pkg::out_beat_t push_q[$];

  task automatic cold_start();
    h_upper  = 8'sd100;
    h_lower  = 8'sd50;
    v_upper  = 8'sd100;
    v_lower  = 8'sd50;
    h_push   = 7'd20;
    h_len    = 15'd50;
    v_push   = 7'd20;
    v_len    = 15'd50;
    go_back  = 1'b0;
    go_fwd   = 1'b0;
    go_up    = 1'b0;
    go_down  = 1'b0;
    fwd_cnt  = '0;
    back_cnt = '0;
    up_cnt   = '0;
    down_cnt = '0;
    fwd_hold = '0;
    up_hold  = '0;
  endtask

  // one pulse counter step; high when it drives its push this tick
  function automatic bit run_pulse(inout logic [15:0] cnt,
                                   input logic [rhpp_pkg::CntW-1:0] lim);
    if (cnt != 16'd0 && cnt < {1'b0, lim}) begin
      cnt = cnt + 16'd1;
      return 1'b1;
    end
    cnt = 16'd0;
    return 1'b0;
  endfunction

  task automatic tick_push(input rhpp_pkg::in_beat_t b, output rhpp_pkg::out_beat_t r);
    logic signed [7:0] h;
    logic signed [7:0] v;
    h = b.horiz_range;
    v = b.vert_range;
    if (b.range_fresh) begin
      if ($signed(h) > $signed(h_upper) && !go_back) begin
        back_cnt = 16'd1;
        go_back  = 1'b1;
      end else if ($signed(h) < $signed(h_lower) && !go_fwd) begin
        fwd_cnt = 16'd1;
        go_fwd  = 1'b1;
      end
      if ($signed(v) > $signed(v_upper) && !go_up) begin
        up_cnt = 16'd1;
        go_up  = 1'b1;
      end else if ($signed(v) < $signed(v_lower) && !go_down) begin
        down_cnt = 16'd1;
        go_down  = 1'b1;
      end
      // horizontal brake is seeded with half the push, vertical with 1
      if (go_back && $signed(h) < $signed(h_upper)) begin
        go_back = 1'b0;
        fwd_cnt = 16'(h_push >> 1);
      end else if (go_fwd && $signed(h) > $signed(h_lower)) begin
        go_fwd   = 1'b0;
        back_cnt = 16'(h_push >> 1);
      end
      if (go_up && $signed(v) < $signed(v_upper)) begin
        go_up    = 1'b0;
        down_cnt = 16'd1;
      end else if (go_down && $signed(v) > $signed(v_lower)) begin
        go_down = 1'b0;
        up_cnt  = 16'd1;
      end
    end
    // later assignment wins: back over forward, down over up
    if (run_pulse(fwd_cnt, h_len))  fwd_hold = {1'b0, h_push};
    if (run_pulse(back_cnt, h_len)) fwd_hold = 8'd0 - {1'b0, h_push};
    if (run_pulse(up_cnt, v_len))   up_hold = {1'b0, v_push};
    if (run_pulse(down_cnt, v_len)) up_hold = 8'd0 - {1'b0, v_push};
    if (up_cnt == 16'd0 && down_cnt == 16'd0) up_hold = '0;
    if (fwd_cnt == 16'd0 && back_cnt == 16'd0) fwd_hold = '0;
    r.forward_push = fwd_hold;
    r.upward_push  = up_hold;
  endtask

  always @(posedge clk) begin
    rhpp_pkg::out_beat_t want;
    if (!rst_n) begin
      cold_start();
      push_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          rhpp_pkg::CFG_HORIZ_UPPER:     h_upper = cfg_data[7:0];
          rhpp_pkg::CFG_HORIZ_LOWER:     h_lower = cfg_data[7:0];
          rhpp_pkg::CFG_VERT_UPPER:      v_upper = cfg_data[7:0];
          rhpp_pkg::CFG_VERT_LOWER:      v_lower = cfg_data[7:0];
          rhpp_pkg::CFG_HORIZ_PUSH:      h_push  = cfg_data[rhpp_pkg::PushW-1:0];
          rhpp_pkg::CFG_HORIZ_PULSE_LEN: h_len   = cfg_data[rhpp_pkg::CntW-1:0];
          rhpp_pkg::CFG_VERT_PUSH:       v_push  = cfg_data[rhpp_pkg::PushW-1:0];
          rhpp_pkg::CFG_VERT_PULSE_LEN:  v_len   = cfg_data[rhpp_pkg::CntW-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (push_q.size() == 0) begin
          $error("unexpected result beat: forward_push %0d, upward_push %0d",
                 out_data.forward_push, out_data.upward_push);
          fails++;
        end else begin
          want = push_q.pop_front();
          checked++;
          if (out_data.forward_push !== want.forward_push) begin
            $error("forward_push mismatch: expected %0d, actual %0d",
                   want.forward_push, out_data.forward_push);
            fails++;
          end
          if (out_data.upward_push !== want.upward_push) begin
            $error("upward_push mismatch: expected %0d, actual %0d",
                   want.upward_push, out_data.upward_push);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        tick_push(in_data, want);
        push_q.push_back(want);
      end
    end
    pending <= push_q.size();
  end

endmodule

[tb/tb_range_hold_push_pulser_top.sv]
`timescale 1ns / 100ps
// Testbench top for the range hold push pulser: clock, reset, stimulus, receiver and verdict.
module tb_range_hold_push_pulser_top;

  localparam int LIMIT    = 400000;
  localparam int HOLD_OFF = 300;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  rhpp_pkg::in_beat_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  rhpp_pkg::out_beat_t           out_data;
  logic                          cfg_wr_en = 1'b0;
  logic [rhpp_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [rhpp_pkg::CfgDataW-1:0] cfg_data  = '0;

  int fails, pending, checked;
  int cycle_cnt  = 0;
  int stall_asks = 0;
  int stall_done = 0;
  int n_settings = 0;
  bit calm       = 1'b0;
  // thresholds in force, used to keep readings near the bands
  int cur_hu = 100, cur_hl = 50, cur_vu = 100, cur_vl = 50;

  range_hold_push_pulser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rhpp_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending),
    .checked   (checked)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // reading near the band, now and then anything at all
  function automatic int near_band(int a, int b);
    int lo, hi;
    lo = ((a < b) ? a : b) - 6;
    hi = ((a > b) ? a : b) + 6;
    if (lo < -128) lo = -128;
    if (hi > 127) hi = 127;
    if ($urandom_range(0, 9) < 2) return int'($signed(8'($urandom)));
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic cfg_write(input logic [rhpp_pkg::CfgIdxW-1:0] idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= rhpp_pkg::CfgDataW'(value);
    @(posedge clk);
  endtask

  task automatic set_config(input int hu, input int hl, input int vu, input int vl,
                            input int hp, input int hlen, input int vp, input int vlen);
    cfg_write(rhpp_pkg::CFG_HORIZ_UPPER, hu & 'hFF);
    cfg_write(rhpp_pkg::CFG_HORIZ_LOWER, hl & 'hFF);
    cfg_write(rhpp_pkg::CFG_VERT_UPPER, vu & 'hFF);
    cfg_write(rhpp_pkg::CFG_VERT_LOWER, vl & 'hFF);
    cfg_write(rhpp_pkg::CFG_HORIZ_PUSH, hp);
    cfg_write(rhpp_pkg::CFG_HORIZ_PULSE_LEN, hlen);
    cfg_write(rhpp_pkg::CFG_VERT_PUSH, vp);
    cfg_write(rhpp_pkg::CFG_VERT_PULSE_LEN, vlen);
    cfg_wr_en <= 1'b0;
    cur_hu = hu;
    cur_hl = hl;
    cur_vu = vu;
    cur_vl = vl;
    n_settings++;
  endtask

  task automatic send_tick(input logic fresh, input int h, input int v);
    rhpp_pkg::in_beat_t b;
    int g;
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    b.range_fresh = fresh;
    b.horiz_range = 8'(h);
    b.vert_range  = 8'(v);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic rand_tick();
    send_tick($urandom_range(0, 99) < 85, near_band(cur_hl, cur_hu), near_band(cur_vl, cur_vu));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side: random ready, a long hold-off on request
  initial begin
    int g;
    @(posedge clk);
    forever begin
      if (stall_done != stall_asks) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        stall_done++;
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        g = pick_gap();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    int hu, hl, vu, vl, n_items;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds: out of band, exactly on a threshold, back in band
    send_tick(1'b0, -128, -128);
    send_tick(1'b1, 75, 75);
    send_tick(1'b1, 127, 127);
    send_tick(1'b1, 100, 100);
    send_tick(1'b1, 99, 99);    // brake starts while push still runs: back/down wins
    send_tick(1'b0, 0, 0);
    send_tick(1'b0, 0, 0);
    send_tick(1'b1, -128, -128);
    send_tick(1'b1, 50, 50);
    send_tick(1'b1, 51, 51);
    send_tick(1'b1, 0, 127);
    send_tick(1'b0, 127, -128);
    send_tick(1'b1, 101, 49);
    send_tick(1'b1, 75, 75);
    repeat (4) send_tick(1'b0, 75, 75);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: set_config(100, 50, 100, 50, 20, 50, 20, 50);
        1: set_config(127, -128, 127, -128, 127, 32767, 127, 32767);
        2: set_config(-128, 127, -128, 127, 0, 0, 0, 0);
        3: set_config(10, -10, 5, -5, 1, 3, 1, 1);     // half push rounds to zero
        4: set_config(20, -20, 40, 0, 127, 12, 64, 9);
        default: begin
          hu = int'($urandom_range(0, 200)) - 100;
          hl = hu - int'($urandom_range(0, 40));
          vu = int'($urandom_range(0, 200)) - 100;
          vl = vu - int'($urandom_range(0, 40));
          if (hl < -128) hl = -128;
          if (vl < -128) vl = -128;
          set_config(hu, hl, vu, vl, $urandom_range(0, 127), $urandom_range(0, 25),
                     $urandom_range(0, 127), $urandom_range(0, 25));
        end
      endcase
      calm = (p == 0);
      if (p == 4) stall_asks++;
      n_items = (p == 1 || p == 2) ? 30 : 80;
      repeat (n_items) rand_tick();
    end
    calm = 1'b0;
    drain();

    $display("Checked %0d result beats over %0d register settings with random gaps,",
             checked, n_settings);
    $display("plus a %0d-cycle result hold-off that backed up the input side.", HOLD_OFF);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
